// ----- rtl/core/mzbt_pkg.sv -----
// Package: constants, zone tables and controller types for the touch zone tracker.
`default_nettype none
package mzbt_pkg;
   localparam int FingerSlots = 10;
   localparam int SlotBits    = 4;
   localparam int RefWidth    = 1024;
   localparam int RefHeight   = 768;
   localparam int GameZones   = 19;
   localparam int MenuZones   = 6;
   localparam int ZoneBits    = 5;
   localparam int ProdBits    = 24;
   localparam int QuotBits    = 24;

   localparam logic [ZoneBits-1:0] ZONE_NONE     = 5'd31;
   localparam logic [ZoneBits-1:0] ZONE_MENU_REQ = 5'd18;

   localparam logic [1:0] CMD_PRESS   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_MOTION  = 2'd2;
   localparam logic [1:0] CMD_OTHER   = 2'd3;

   localparam logic [1:0] ST_IGNORED = 2'd0;
   localparam logic [1:0] ST_HANDLED = 2'd1;
   localparam logic [1:0] ST_MENU    = 2'd2;

   localparam logic [1:0] REG_ENABLED  = 2'd0;
   localparam logic [1:0] REG_MENU_SEL = 2'd1;
   localparam logic [1:0] REG_WIDTH    = 2'd2;
   localparam logic [1:0] REG_HEIGHT   = 2'd3;

   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
      logic [10:0] w;
      logic [10:0] h;
      logic [15:0] value;
   } zone_type;

   function automatic zone_type zone_entry(input logic menu, input logic [ZoneBits-1:0] i);
      zone_type z;
      z = '{x: 11'd0, y: 11'd0, w: 11'd0, h: 11'd0, value: 16'd0};
      if (menu) begin
         case (i)
            5'd0: z = '{11'd100, 11'd510, 11'd100, 11'd80, 16'd0};
            5'd1: z = '{11'd100, 11'd678, 11'd100, 11'd80, 16'd1};
            5'd2: z = '{11'd10,  11'd594, 11'd100, 11'd80, 16'd2};
            5'd3: z = '{11'd190, 11'd594, 11'd100, 11'd80, 16'd3};
            5'd4: z = '{11'd734, 11'd594, 11'd120, 11'd80, 16'd5};
            5'd5: z = '{11'd874, 11'd594, 11'd120, 11'd80, 16'd4};
            default: ;
         endcase
      end else begin
         case (i)
            5'd0:  z = '{11'd80,  11'd525, 11'd80,  11'd80, 16'h0010};
            5'd1:  z = '{11'd80,  11'd685, 11'd80,  11'd80, 16'h0040};
            5'd2:  z = '{11'd0,   11'd605, 11'd80,  11'd80, 16'h0080};
            5'd3:  z = '{11'd160, 11'd605, 11'd80,  11'd80, 16'h0020};
            5'd4:  z = '{11'd160, 11'd525, 11'd80,  11'd80, 16'h0030};
            5'd5:  z = '{11'd0,   11'd525, 11'd80,  11'd80, 16'h0090};
            5'd6:  z = '{11'd160, 11'd685, 11'd80,  11'd80, 16'h0060};
            5'd7:  z = '{11'd0,   11'd685, 11'd80,  11'd80, 16'h00C0};
            5'd8:  z = '{11'd864, 11'd525, 11'd80,  11'd80, 16'h1000};
            5'd9:  z = '{11'd864, 11'd685, 11'd80,  11'd80, 16'h4000};
            5'd10: z = '{11'd784, 11'd605, 11'd80,  11'd80, 16'h8000};
            5'd11: z = '{11'd944, 11'd605, 11'd80,  11'd80, 16'h2000};
            5'd12: z = '{11'd0,   11'd338, 11'd120, 11'd60, 16'h0400};
            5'd13: z = '{11'd0,   11'd398, 11'd120, 11'd60, 16'h0100};
            5'd14: z = '{11'd904, 11'd338, 11'd120, 11'd60, 16'h0800};
            5'd15: z = '{11'd904, 11'd398, 11'd120, 11'd60, 16'h0200};
            5'd16: z = '{11'd400, 11'd708, 11'd100, 11'd60, 16'h0001};
            5'd17: z = '{11'd524, 11'd708, 11'd100, 11'd60, 16'h0008};
            5'd18: z = '{11'd462, 11'd0,   11'd100, 11'd50, 16'h0000};
            default: ;
         endcase
      end
      return z;
   endfunction

   typedef enum logic [2:0] {
      S_IDLE, S_DIVIDE, S_SCAN, S_UPDATE, S_MASK, S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture item, start divisions
      logic div_step;  // one quotient bit for x and y
      logic scan_step; // test one zone
      logic apply;     // update finger table, set status
      logic mask_clr;
      logic mask_step; // fold one finger into the mask
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic scan_done;
      logic mask_done;
      logic need_scan;
      logic need_mask;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/core/mzbt_ctrl.sv -----
// Controller: sequences division, zone scan, finger update and mask rebuild.
`default_nettype none
module mzbt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire mzbt_pkg::sts_type sts,
   output mzbt_pkg::cmd_type     cmd
);
   import mzbt_pkg::*;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = sts.need_scan ? S_SCAN : S_UPDATE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.apply    = 1'b1;
            cmd.mask_clr = 1'b1;
            state_in     = sts.need_mask ? S_MASK : S_OUT;
         end
         S_MASK: begin
            cmd.mask_step = 1'b1;
            if (sts.mask_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ----- rtl/core/mzbt_datapath.sv -----
// Datapath: registers, coordinate dividers, zone scanner, finger table and mask.
`default_nettype none
module mzbt_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          req_command,
   input  wire logic [3:0]          req_finger_id,
   input  wire logic [11:0]         req_touch_x,
   input  wire logic [11:0]         req_touch_y,
   input  wire logic                req_contact_held,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [11:0]         csr_data,
   input  wire mzbt_pkg::cmd_type   cmd,
   output mzbt_pkg::sts_type        sts,
   output logic [1:0]               rsp_status,
   output logic [15:0]              rsp_pad_buttons,
   output logic                     rsp_tap_valid,
   output logic [2:0]               rsp_tap_key
);
   import mzbt_pkg::*;

   logic enabled_ff, menu_ff;
   logic [11:0] width_ff, height_ff;
   logic [ZoneBits-1:0] finger_ff [FingerSlots];
   logic [15:0] mask_ff, mask_in;

   logic [1:0] cmd_ff;
   logic [SlotBits-1:0] fid_ff;
   logic held_ff;
   // restoring dividers
   logic [ProdBits-1:0] xnum_ff, ynum_ff;
   logic [QuotBits-1:0] xq_ff, yq_ff;
   logic [12:0] xr_ff, yr_ff;
   logic [4:0] div_cnt_ff;
   logic [ZoneBits-1:0] zidx_ff, hit_ff;
   logic hit_found_ff;
   logic [SlotBits-1:0] mslot_ff;
   logic [1:0] status_ff;
   logic tap_v_ff;
   logic [2:0] tap_k_ff;
   logic [1:0] rsp_status_ff;
   logic [15:0] rsp_pad_ff;
   logic rsp_tap_v_ff;
   logic [2:0] rsp_tap_k_ff;

   logic [12:0] xr_sh, yr_sh;
   logic [QuotBits-1:0] sx, sy;
   zone_type zc;
   logic in_zone, last_zone;
   logic [ZoneBits-1:0] zone_count;
   zone_type zf;
   zone_type zt;
   logic active;
   logic menu_chg;

   assign sx = (width_ff == 12'd0) ? '1 : xq_ff;
   assign sy = (height_ff == 12'd0) ? '1 : yq_ff;
   assign xr_sh = {xr_ff[11:0], xnum_ff[ProdBits-1]};
   assign yr_sh = {yr_ff[11:0], ynum_ff[ProdBits-1]};

   assign zone_count = menu_ff ? ZoneBits'(MenuZones) : ZoneBits'(GameZones);
   assign zc = zone_entry(menu_ff, zidx_ff);
   assign in_zone = sx >= QuotBits'(zc.x) && sx < QuotBits'(zc.x) + QuotBits'(zc.w)
                 && sy >= QuotBits'(zc.y) && sy < QuotBits'(zc.y) + QuotBits'(zc.h);
   assign last_zone = zidx_ff == zone_count - 5'd1;
   assign zf = zone_entry(1'b0, finger_ff[mslot_ff]);
   assign zt = zone_entry(1'b1, hit_ff);

   // mode change drops every finger and the mask
   assign menu_chg = csr_write && csr_index == REG_MENU_SEL && csr_data[0] != menu_ff;

   assign active = enabled_ff;
   assign sts.div_done  = div_cnt_ff == 5'd0;
   assign sts.scan_done = hit_found_ff || in_zone || last_zone;
   assign sts.mask_done = mslot_ff == SlotBits'(FingerSlots - 1);
   assign sts.need_scan = active && (cmd_ff == CMD_PRESS ||
                          (cmd_ff == CMD_MOTION && !menu_ff && held_ff));
   assign sts.need_mask = active && !menu_ff && ((cmd_ff == CMD_RELEASE) ||
                          (cmd_ff == CMD_MOTION && held_ff) ||
                          (cmd_ff == CMD_PRESS && hit_ff != ZONE_NONE &&
                           hit_ff != ZONE_MENU_REQ));

   assign rsp_status      = rsp_status_ff;
   assign rsp_pad_buttons = rsp_pad_ff;
   assign rsp_tap_valid   = rsp_tap_v_ff;
   assign rsp_tap_key     = rsp_tap_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         menu_ff    <= 1'b0;
         width_ff   <= 12'(RefWidth);
         height_ff  <= 12'(RefHeight);
         mask_ff    <= '0;
         for (int i = 0; i < FingerSlots; i++) finger_ff[i] <= ZONE_NONE;
      end else begin
         mask_ff <= mask_in;
         if (csr_write) begin
            case (csr_index)
               REG_ENABLED: enabled_ff <= csr_data[0];
               REG_MENU_SEL: if (menu_chg) begin
                  menu_ff <= csr_data[0];
                  for (int i = 0; i < FingerSlots; i++) finger_ff[i] <= ZONE_NONE;
               end
               REG_WIDTH:  width_ff  <= csr_data;
               REG_HEIGHT: height_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.apply && active) begin
            if (cmd_ff == CMD_RELEASE) begin
               if (menu_ff) begin
                  for (int i = 0; i < FingerSlots; i++) finger_ff[i] <= ZONE_NONE;
               end else finger_ff[fid_ff] <= ZONE_NONE;
            end else if (cmd_ff == CMD_MOTION && !menu_ff && held_ff) begin
               finger_ff[fid_ff] <= hit_ff;
            end else if (cmd_ff == CMD_PRESS && hit_ff != ZONE_NONE &&
                         (menu_ff || hit_ff != ZONE_MENU_REQ)) begin
               finger_ff[fid_ff] <= hit_ff;
            end
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (cmd.mask_clr && sts.need_mask) mask_in = '0;
      if (cmd.mask_step && finger_ff[mslot_ff] < ZoneBits'(GameZones))
         mask_in = mask_ff | zf.value;
      if (menu_chg) mask_in = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff     <= req_command;
         fid_ff     <= (req_finger_id >= SlotBits'(FingerSlots)) ? '0 : req_finger_id;
         held_ff    <= req_contact_held;
         xnum_ff    <= ProdBits'(req_touch_x) * ProdBits'(RefWidth);
         ynum_ff    <= ProdBits'(req_touch_y) * ProdBits'(RefHeight);
         xr_ff      <= '0;
         yr_ff      <= '0;
         div_cnt_ff <= 5'(ProdBits);
         zidx_ff    <= '0;
         hit_ff     <= ZONE_NONE;
         hit_found_ff <= 1'b0;
      end
      if (cmd.div_step && div_cnt_ff != 5'd0) begin
         div_cnt_ff <= div_cnt_ff - 5'd1;
         xnum_ff <= xnum_ff << 1;
         ynum_ff <= ynum_ff << 1;
         if (xr_sh >= {1'b0, width_ff}) begin
            xr_ff <= xr_sh - {1'b0, width_ff};
            xq_ff <= {xq_ff[QuotBits-2:0], 1'b1};
         end else begin
            xr_ff <= xr_sh;
            xq_ff <= {xq_ff[QuotBits-2:0], 1'b0};
         end
         if (yr_sh >= {1'b0, height_ff}) begin
            yr_ff <= yr_sh - {1'b0, height_ff};
            yq_ff <= {yq_ff[QuotBits-2:0], 1'b1};
         end else begin
            yr_ff <= yr_sh;
            yq_ff <= {yq_ff[QuotBits-2:0], 1'b0};
         end
      end
      if (cmd.scan_step && !hit_found_ff) begin
         if (in_zone) begin
            hit_ff <= zidx_ff;
            hit_found_ff <= 1'b1;
         end else if (!last_zone) zidx_ff <= zidx_ff + 5'd1;
      end
      if (cmd.apply) begin
         mslot_ff <= '0;
         status_ff <= ST_IGNORED;
         tap_v_ff  <= 1'b0;
         tap_k_ff  <= '0;
         if (active && cmd_ff != CMD_OTHER) begin
            status_ff <= ST_HANDLED;
            if (cmd_ff == CMD_PRESS && hit_ff != ZONE_NONE) begin
               if (!menu_ff && hit_ff == ZONE_MENU_REQ) status_ff <= ST_MENU;
               else if (menu_ff) begin
                  tap_v_ff <= 1'b1;
                  tap_k_ff <= zt.value[2:0];
               end
            end
         end
      end
      if (cmd.mask_step) mslot_ff <= mslot_ff + 4'd1;
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_pad_ff    <= mask_ff;
         rsp_tap_v_ff  <= tap_v_ff;
         rsp_tap_k_ff  <= tap_k_ff;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/multitouch_zone_button_tracker_unit.sv -----
// Top level of the multitouch zone button tracker.
`default_nettype none
// Usage:
//  req_ channel carries one touch event per transfer (command, finger,
//  x, y, contact held). rsp_ channel returns exactly one result per event:
//  status, gamepad mask, tap flag and tap key.
//  csr_ port writes enabled, menu select, screen_width, screen_height with no
//  wait; write only while the block is idle.
//  One event at a time. Steps in order: load, division (24 quotient bits
//  for x and y in parallel, then the done check), up to 19 zone tests one
//  per cycle, update, a mask rebuild over all 10 finger slots, output;
//  events that need no scan or mask skip those steps.
//  req_stall is low only while idle. The result sits in an output register;
//  if rsp_stall holds it, the next event still runs and waits in its final
//  state until the register frees.
//  Reset (synchronous, active high) clears every finger to no zone, the mask
//  to zero, enabled and menu select to zero, and the screen size to 1024x768.
module multitouch_zone_button_tracker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [3:0]  req_finger_id,
   input  wire logic [11:0] req_touch_x,
   input  wire logic [11:0] req_touch_y,
   input  wire logic        req_contact_held,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_pad_buttons,
   output logic             rsp_tap_valid,
   output logic [2:0]       rsp_tap_key,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data
);
   import mzbt_pkg::*;
   cmd_type cmd;
   sts_type sts;

   mzbt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   mzbt_datapath u_dp (
      .clock, .reset, .req_command, .req_finger_id, .req_touch_x, .req_touch_y,
      .req_contact_held, .csr_write, .csr_index, .csr_data, .cmd, .sts,
      .rsp_status, .rsp_pad_buttons, .rsp_tap_valid, .rsp_tap_key
   );
endmodule
`default_nettype wire

// ----- tb/sv/mzbt_scoreboard.sv -----
// Checker for the touch zone tracker: predicts each result and compares it.
`default_nettype none
module mzbt_scoreboard (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [3:0]  req_finger_id,
   input  wire logic [11:0] req_touch_x,
   input  wire logic [11:0] req_touch_y,
   input  wire logic        req_contact_held,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [15:0] rsp_pad_buttons,
   input  wire logic        rsp_tap_valid,
   input  wire logic [2:0]  rsp_tap_key,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [11:0] csr_data,
   output int               mismatches,
   output int               outstanding
);
   import mzbt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] pad;
      logic        tap_valid;
      logic [2:0]  tap_key;
   } touch_result_type;

   // zone geometry in reference pixels: x, y, w, h, value
   localparam int GameRect [GameZones][5] = '{
      '{80, 525, 80, 80, 'h0010}, '{80, 685, 80, 80, 'h0040},
      '{0, 605, 80, 80, 'h0080},  '{160, 605, 80, 80, 'h0020},
      '{160, 525, 80, 80, 'h0030}, '{0, 525, 80, 80, 'h0090},
      '{160, 685, 80, 80, 'h0060}, '{0, 685, 80, 80, 'h00C0},
      '{864, 525, 80, 80, 'h1000}, '{864, 685, 80, 80, 'h4000},
      '{784, 605, 80, 80, 'h8000}, '{944, 605, 80, 80, 'h2000},
      '{0, 338, 120, 60, 'h0400}, '{0, 398, 120, 60, 'h0100},
      '{904, 338, 120, 60, 'h0800}, '{904, 398, 120, 60, 'h0200},
      '{400, 708, 100, 60, 'h0001}, '{524, 708, 100, 60, 'h0008},
      '{462, 0, 100, 50, 'h0000}};
   localparam int MenuRect [MenuZones][5] = '{
      '{100, 510, 100, 80, 0}, '{100, 678, 100, 80, 1}, '{10, 594, 100, 80, 2},
      '{190, 594, 100, 80, 3}, '{734, 594, 120, 80, 5}, '{874, 594, 120, 80, 4}};

   logic               is_enabled, is_menu;
   logic [11:0]        scr_w, scr_h;
   logic [4:0]         held_zone [FingerSlots];
   logic [15:0]        pad_mask;
   touch_result_type   result_q [$];

   function automatic logic [31:0] to_ref(logic [11:0] v, int unsigned r, logic [11:0] sz);
      if (sz == 0) return 32'hFFFF_FFFF;
      return (32'(v) * r) / 32'(sz);
   endfunction

   function automatic logic [4:0] locate(logic [11:0] x, logic [11:0] y);
      logic [31:0] sx, sy;
      int n;
      sx = to_ref(x, RefWidth, scr_w);
      sy = to_ref(y, RefHeight, scr_h);
      n = is_menu ? MenuZones : GameZones;
      for (int i = 0; i < n; i++) begin
         int zx, zy, zw, zh;
         zx = is_menu ? MenuRect[i][0] : GameRect[i][0];
         zy = is_menu ? MenuRect[i][1] : GameRect[i][1];
         zw = is_menu ? MenuRect[i][2] : GameRect[i][2];
         zh = is_menu ? MenuRect[i][3] : GameRect[i][3];
         if (sx >= zx && sx < zx + zw && sy >= zy && sy < zy + zh) return 5'(i);
      end
      return ZONE_NONE;
   endfunction

   function automatic void forget_fingers();
      foreach (held_zone[i]) held_zone[i] = ZONE_NONE;
   endfunction

   function automatic void refold_mask();
      pad_mask = '0;
      if (!is_menu)
         foreach (held_zone[i])
            if (held_zone[i] < GameZones) pad_mask |= 16'(GameRect[held_zone[i]][4]);
   endfunction

   function automatic touch_result_type track_touch(logic [1:0] cmd, logic [3:0] fid,
                                                    logic [11:0] x, logic [11:0] y,
                                                    logic held);
      touch_result_type r;
      logic [4:0] z;
      r = '0;
      if (fid >= FingerSlots) fid = 0;
      if (is_enabled) begin
         case (cmd)
            CMD_PRESS: begin
               r.status = ST_HANDLED;
               z = locate(x, y);
               if (z != ZONE_NONE) begin
                  if (!is_menu && z == ZONE_MENU_REQ) begin
                     r.status = ST_MENU;
                  end else begin
                     held_zone[fid] = z;
                     if (is_menu) begin
                        r.tap_valid = 1'b1;
                        r.tap_key = 3'(MenuRect[z][4]);
                     end else begin
                        refold_mask();
                     end
                  end
               end
            end
            CMD_RELEASE: begin
               r.status = ST_HANDLED;
               if (is_menu) begin
                  forget_fingers();
               end else begin
                  held_zone[fid] = ZONE_NONE;
                  refold_mask();
               end
            end
            CMD_MOTION: begin
               r.status = ST_HANDLED;
               if (!is_menu && held) begin
                  held_zone[fid] = locate(x, y);
                  refold_mask();
               end
            end
            default: ;
         endcase
      end
      r.pad = pad_mask;
      return r;
   endfunction

   assign outstanding = result_q.size();

   always @(posedge clock) begin
      touch_result_type want, got;
      if (reset) begin
         is_enabled = 1'b0;
         is_menu = 1'b0;
         scr_w = 12'd1024;
         scr_h = 12'd768;
         forget_fingers();
         pad_mask = '0;
         result_q.delete();
         mismatches <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_ENABLED: is_enabled = csr_data[0];
               REG_MENU_SEL: if (csr_data[0] != is_menu) begin
                  is_menu = csr_data[0];
                  forget_fingers();
                  pad_mask = '0;
               end
               REG_WIDTH: scr_w = csr_data;
               REG_HEIGHT: scr_h = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            result_q.push_back(track_touch(req_command, req_finger_id, req_touch_x,
                                           req_touch_y, req_contact_held));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_pad_buttons, rsp_tap_valid, rsp_tap_key};
            if (result_q.size() == 0) begin
               if (mismatches < 10) $display("ERROR: unexpected result %p", got);
               mismatches <= mismatches + 1;
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     $display("ERROR: result mismatch: expected %p, got %p", want, got);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// ----- tb/sv/multitouch_zone_button_tracker_unit_tb.sv -----
// Testbench top: stimulus, handshake pacing and verdict for the touch tracker.
`default_nettype none
module multitouch_zone_button_tracker_unit_tb;
   import mzbt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1_000_000;
   localparam int DrainCycles = 80;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic [3:0]  req_finger_id = '0;
   logic [11:0] req_touch_x = '0;
   logic [11:0] req_touch_y = '0;
   logic        req_contact_held = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_pad_buttons;
   logic        rsp_tap_valid;
   logic [2:0]  rsp_tap_key;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   int  mismatches, outstanding;
   int  cycles = 0;
   bit  quiet = 1'b0;   // no idling on either side while set
   int  hold_left = 0;
   logic [11:0] cur_w = 12'd1024, cur_h = 12'd768;
   logic cur_menu = 1'b0;

   always #6 clock = ~clock;

   multitouch_zone_button_tracker_unit dut (.*);

   mzbt_scoreboard checker_i (.*);

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver back-pressure: fresh stall length after every result transfer
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) hold_left = quiet ? 0 : $urandom_range(0, 11);
      else if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0);
   end

   task automatic send_touch(logic [1:0] cmd, logic [3:0] fid, logic [11:0] x,
                             logic [11:0] y, logic held);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_finger_id <= fid;
      req_touch_x <= x;
      req_touch_y <= y;
      req_contact_held <= held;
      do @(posedge clock); while (req_stall);
   endtask

   // lets the block drain before a register write
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [11:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_MENU_SEL: cur_menu = val[0];
         REG_WIDTH: cur_w = val;
         REG_HEIGHT: cur_h = val;
         default: ;
      endcase
   endtask

   // reference point to screen pixels, rounded up so it scales back onto the point
   function automatic logic [11:0] to_screen(int r, int unsigned full, logic [11:0] sz);
      int unsigned v;
      v = (r * sz + full - 1) / full;
      return (v > 4095) ? 12'd4095 : 12'(v);
   endfunction

   task automatic random_touch();
      logic [1:0] cmd;
      logic [3:0] fid;
      logic [11:0] x, y;
      zone_type z;
      int pick, rx, ry;
      pick = $urandom_range(0, 9);
      cmd = (pick < 4) ? CMD_PRESS : (pick < 6) ? CMD_RELEASE :
            (pick < 9) ? CMD_MOTION : CMD_OTHER;
      fid = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      if ($urandom_range(0, 3) != 0) begin
         // aim at a zone of the current table, corners now and then
         z = zone_entry(cur_menu, 5'($urandom_range(0, cur_menu ? MenuZones - 1
                                                                : GameZones - 1)));
         case ($urandom_range(0, 5))
            0: begin rx = z.x; ry = z.y; end
            1: begin rx = z.x + z.w - 1; ry = z.y + z.h - 1; end
            2: begin rx = z.x + z.w; ry = z.y + z.h; end
            default: begin
               rx = z.x + $urandom_range(0, z.w - 1);
               ry = z.y + $urandom_range(0, z.h - 1);
            end
         endcase
         x = to_screen(rx, RefWidth, cur_w);
         y = to_screen(ry, RefHeight, cur_h);
      end else begin
         x = 12'($urandom);
         y = 12'($urandom);
      end
      send_touch(cmd, fid, x, y, 1'($urandom));
   endtask

   initial begin
      logic [11:0] sizes [6];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: everything ignored
      send_touch(CMD_PRESS, 4'd0, 12'd100, 12'd550, 1'b0);
      send_touch(CMD_MOTION, 4'd3, 12'd100, 12'd550, 1'b1);
      settle();
      write_reg(REG_ENABLED, 12'd1);

      // game mode at the reference size
      send_touch(CMD_PRESS, 4'd0, 12'd100, 12'd550, 1'b0);    // up
      send_touch(CMD_PRESS, 4'd1, 12'd170, 12'd530, 1'b0);    // diagonal up-right
      send_touch(CMD_PRESS, 4'd2, 12'd500, 12'd10, 1'b0);     // menu request
      send_touch(CMD_PRESS, 4'd3, 12'd500, 12'd400, 1'b0);    // no zone
      send_touch(CMD_MOTION, 4'd0, 12'd10, 12'd610, 1'b1);    // slide to left
      send_touch(CMD_MOTION, 4'd1, 12'd470, 12'd20, 1'b1);    // slide onto menu zone
      send_touch(CMD_MOTION, 4'd0, 12'd870, 12'd700, 1'b0);   // not held: ignored
      send_touch(CMD_MOTION, 4'd0, 12'd500, 12'd300, 1'b1);   // slide off every zone
      send_touch(CMD_PRESS, 4'd15, 12'd1023, 12'd684, 1'b0);  // finger folded to slot 0
      send_touch(CMD_PRESS, 4'd9, 12'd4095, 12'd4095, 1'b1);
      send_touch(CMD_OTHER, 4'd9, 12'd0, 12'd0, 1'b1);
      send_touch(CMD_RELEASE, 4'd1, 12'd0, 12'd0, 1'b0);
      settle();

      // menu mode taps, motion and release
      write_reg(REG_MENU_SEL, 12'd1);
      send_touch(CMD_PRESS, 4'd0, 12'd150, 12'd550, 1'b0);
      send_touch(CMD_PRESS, 4'd1, 12'd150, 12'd700, 1'b0);
      send_touch(CMD_PRESS, 4'd2, 12'd20, 12'd600, 1'b0);
      send_touch(CMD_PRESS, 4'd3, 12'd200, 12'd600, 1'b0);
      send_touch(CMD_PRESS, 4'd4, 12'd740, 12'd600, 1'b0);
      send_touch(CMD_PRESS, 4'd5, 12'd993, 12'd673, 1'b0);
      send_touch(CMD_MOTION, 4'd5, 12'd150, 12'd550, 1'b1);
      send_touch(CMD_RELEASE, 4'd5, 12'd0, 12'd0, 1'b0);
      settle();

      // zero width: nothing can be hit
      write_reg(REG_WIDTH, 12'd0);
      send_touch(CMD_PRESS, 4'd0, 12'd150, 12'd550, 1'b0);
      settle();

      sizes = '{12'd1024, 12'd4095, 12'd1, 12'd2048, 12'd768, 12'd0};
      for (int phase = 0; phase < 14; phase++) begin
         settle();
         quiet = (phase % 4 == 3);
         write_reg(REG_ENABLED, 12'(($urandom_range(0, 7) != 0)));
         write_reg(REG_MENU_SEL, 12'(($urandom_range(0, 2) == 0)));
         write_reg(REG_WIDTH, ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                                         : sizes[$urandom_range(0, 5)]);
         write_reg(REG_HEIGHT, ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                                          : sizes[$urandom_range(0, 5)]);
         for (int k = 0; k < 125; k++) random_touch();
      end

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
